[design/jmbs_pkg.sv]
// shared types, constants and register codes of the jet multiplicity crossing selector
package jmbs_pkg;

  localparam int MAX_SLOTS    = 4;
  localparam int PACKED_SLOTS = 4;
  localparam int NUM_SLOTS    = (MAX_SLOTS < PACKED_SLOTS) ? MAX_SLOTS : PACKED_SLOTS;

  localparam int CROSSING_W = 12;
  localparam int PT_W       = 11;
  localparam int ETA_W      = 8;
  localparam int CONST_W    = 8;
  localparam int COUNT_W    = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 44;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_JET_COUNT    = 3'd0,
    REG_PT_THRESHOLDS    = 3'd1,
    REG_ETA_LIMITS       = 3'd2,
    REG_ETA_CUT_ENABLE   = 3'd3,
    REG_CONST_THRESHOLDS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] min_jet_count;
    logic [43:0]        pt_thresholds;
    logic [31:0]        eta_limits;
    logic [3:0]         eta_cut_enable;
    logic [31:0]        const_thresholds;
  } cfg_t;

  // one classified jet: per-slot pass flags are independent of the running count
  typedef struct packed {
    logic [CROSSING_W-1:0] crossing;
    logic [NUM_SLOTS-1:0]  pass;
    logic                  last;
  } jet_entry_t;

endpackage

[design/jmbs_front.sv]
// front end: accepts jets and evaluates all slot cuts into a registered entry
module jmbs_front import jmbs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [CROSSING_W-1:0] in_crossing,
  input  logic        [PT_W-1:0]       in_jet_pt,
  input  logic signed [ETA_W-1:0]      in_jet_eta,
  input  logic        [CONST_W-1:0]    in_jet_constituents,
  input  logic                         in_last_in_crossing,
  output logic                         ent_valid,
  input  logic                         ent_ready,
  output jet_entry_t                   ent
);

  logic       valid_r, valid_nxt;
  jet_entry_t ent_r;
  logic [ETA_W:0] abs_eta;
  logic [NUM_SLOTS-1:0] pass;
  logic take;

  // 9-bit magnitude so that -128 maps to 128
  always_comb begin
    if (in_jet_eta[ETA_W-1]) begin
      abs_eta = (ETA_W+1)'(0) - {in_jet_eta[ETA_W-1], in_jet_eta};
    end else begin
      abs_eta = {1'b0, in_jet_eta};
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      pass[s] = (in_jet_pt >= cfg.pt_thresholds[PT_W*s +: PT_W])
             && (!cfg.eta_cut_enable[s] || (abs_eta < {1'b0, cfg.eta_limits[ETA_W*s +: ETA_W]}))
             && (in_jet_constituents >= cfg.const_thresholds[CONST_W*s +: CONST_W]);
    end
  end

  assign in_ready  = !valid_r || ent_ready;
  assign take      = in_valid && in_ready;
  assign ent_valid = valid_r;
  assign ent       = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (ent_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r.crossing <= in_crossing;
      ent_r.pass     <= pass;
      ent_r.last     <= in_last_in_crossing;
    end
  end

endmodule

[design/jmbs_fifo.sv]
// short queue of classified jets between front and back ends
module jmbs_fifo import jmbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  jet_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output jet_entry_t pop_data
);

  jet_entry_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/jmbs_back.sv]
// back end: running accepted-jet count per crossing and the result register
module jmbs_back import jmbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COUNT_W-1:0]    min_jet_count,
  input  logic                  ent_valid,
  output logic                  ent_ready,
  input  jet_entry_t            ent,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CROSSING_W-1:0] out_selected_crossing
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CROSSING_W-1:0] crossing_r;
  logic [COUNT_W-1:0]    count_inc;
  logic                  slot_ok, accept_jet, pop, emit;

  assign ent_ready = !out_valid_r || out_ready;
  assign pop       = ent_valid && ent_ready;

  // slot exists and the requirement is not yet met
  assign slot_ok    = ({1'b0, count_r} < (COUNT_W+1)'(NUM_SLOTS)) && (count_r < min_jet_count);
  assign accept_jet = slot_ok && ent.pass[count_r[SLOT_W-1:0]];
  assign count_inc  = accept_jet ? count_r + COUNT_W'(1) : count_r;
  assign emit       = pop && ent.last && (count_inc >= min_jet_count);

  always_comb begin
    count_nxt = count_r;
    if (pop) begin
      count_nxt = ent.last ? '0 : count_inc;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      crossing_r <= ent.crossing;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_selected_crossing = crossing_r;

endmodule

[design/jet_multiplicity_bx_selector_core.sv]
// top level of the jet multiplicity crossing selector: config registers and the three stages
// Takes one jet per clock, grouped by bunch crossing with the final jet flagged by
// in_last_in_crossing, and emits the crossing number on the out_ channel when enough jets
// passed the per-slot pt, |eta| and constituent cuts. Sustained rate is one jet per cycle
// as long as out_ready is high; the front end evaluates every slot's cuts at once, so the
// only serial step, the running accepted-jet count, is a single increment in the back end.
// From input transaction to result a jet passes the front register, the queue and the output
// register. The four-entry queue absorbs short output stalls before in_ready drops.
// Configuration writes (cfg_ready is always high) must only be issued while no jets are
// in flight; indexes beyond the register list are ignored.
module jet_multiplicity_bx_selector_core import jmbs_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  // jet input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [CROSSING_W-1:0] in_crossing,
  input  logic        [PT_W-1:0]       in_jet_pt,
  input  logic signed [ETA_W-1:0]      in_jet_eta,
  input  logic        [CONST_W-1:0]    in_jet_constituents,
  input  logic                         in_last_in_crossing,
  // selected crossing output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [CROSSING_W-1:0] out_selected_crossing
);

  cfg_t       cfg_r;
  logic       fr_valid, fr_ready;
  jet_entry_t fr_ent;
  logic       bk_valid, bk_ready;
  jet_entry_t bk_ent;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_JET_COUNT:    cfg_r.min_jet_count    <= cfg_data[COUNT_W-1:0];
        REG_PT_THRESHOLDS:    cfg_r.pt_thresholds    <= cfg_data[43:0];
        REG_ETA_LIMITS:       cfg_r.eta_limits       <= cfg_data[31:0];
        REG_ETA_CUT_ENABLE:   cfg_r.eta_cut_enable   <= cfg_data[3:0];
        REG_CONST_THRESHOLDS: cfg_r.const_thresholds <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify against every slot
  jmbs_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_crossing         (in_crossing),
    .in_jet_pt           (in_jet_pt),
    .in_jet_eta          (in_jet_eta),
    .in_jet_constituents (in_jet_constituents),
    .in_last_in_crossing (in_last_in_crossing),
    .ent_valid           (fr_valid),
    .ent_ready           (fr_ready),
    .ent                 (fr_ent)
  );

  // decoupling queue
  jmbs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_ent),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_ent)
  );

  // back: count accepted jets and decide at the end of each crossing
  jmbs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .min_jet_count         (cfg_r.min_jet_count),
    .ent_valid             (bk_valid),
    .ent_ready             (bk_ready),
    .ent                   (bk_ent),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_selected_crossing (out_selected_crossing)
  );

endmodule

[test/tb_jet_multiplicity_bx_selector_core.sv]
// testbench for the jet multiplicity crossing selector: directed and random jet streams
module tb_jet_multiplicity_bx_selector_core;
  timeunit 1ns;
  timeprecision 1ps;

  import jmbs_pkg::*;

  // quiet cycles tolerated before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 2000;
  // pipeline is three deep; the extra drain wait covers jets that never produce a crossing
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_CFG_REGS    = 5;
  localparam int ITEMS_PER_PHASE = 175;

  logic clk = 1'b0;
  logic rst_n;

  logic                         cfg_valid;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index;
  logic        [CFG_DATA_W-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic        [CROSSING_W-1:0] in_crossing;
  logic        [PT_W-1:0]       in_jet_pt;
  logic signed [ETA_W-1:0]      in_jet_eta;
  logic        [CONST_W-1:0]    in_jet_constituents;
  logic                         in_last_in_crossing;
  logic                         out_valid;
  logic                         out_ready;
  logic        [CROSSING_W-1:0] out_selected_crossing;

  // shadow copy of the selection registers and the running jet count
  logic [COUNT_W-1:0] min_jets_req     = '0;
  logic [43:0]        pt_min_packed    = '0;
  logic [31:0]        eta_max_packed   = '0;
  logic [3:0]         eta_cut_on       = '0;
  logic [31:0]        const_min_packed = '0;
  logic [COUNT_W-1:0] jets_taken       = '0;

  // crossings the selector still owes us, oldest first
  logic [CROSSING_W-1:0] selected_q[$];

  int failures     = 0;
  int quiet_cycles = 0;
  int idle_pct     = 15;
  bit steady       = 1'b0;

  jet_multiplicity_bx_selector_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_crossing           (in_crossing),
    .in_jet_pt             (in_jet_pt),
    .in_jet_eta            (in_jet_eta),
    .in_jet_constituents   (in_jet_constituents),
    .in_last_in_crossing   (in_last_in_crossing),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_selected_crossing (out_selected_crossing)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // all three cuts of one threshold slot; slots past the available ones reject everything
  function automatic bit jet_meets_slot(int unsigned slot, logic [PT_W-1:0] pt,
                                        int unsigned abs_eta, logic [CONST_W-1:0] nc);
    if (slot >= NUM_SLOTS) return 1'b0;
    if (pt < pt_min_packed[PT_W*slot +: PT_W]) return 1'b0;
    if (eta_cut_on[slot] && abs_eta >= eta_max_packed[8*slot +: 8]) return 1'b0;
    if (nc < const_min_packed[8*slot +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the jet count for one accepted jet and queue the crossing it selects, if any
  function automatic void count_jet(logic [CROSSING_W-1:0] xing, logic [PT_W-1:0] pt,
                                    logic signed [ETA_W-1:0] eta, logic [CONST_W-1:0] nc,
                                    logic last);
    int unsigned abs_eta;
    // -128 folds to 128, one past the signed range
    abs_eta = (eta < 0) ? -int'(eta) : int'(eta);
    if (jets_taken < min_jets_req && jet_meets_slot(jets_taken, pt, abs_eta, nc))
      jets_taken = jets_taken + 1'b1;
    if (last) begin
      if (jets_taken >= min_jets_req) selected_q.push_back(xing);
      jets_taken = '0;
    end
  endfunction

  // mirror of a register write; unknown indexes leave everything alone
  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_JET_COUNT:    min_jets_req     = data[COUNT_W-1:0];
      REG_PT_THRESHOLDS:    pt_min_packed    = data[43:0];
      REG_ETA_LIMITS:       eta_max_packed   = data[31:0];
      REG_ETA_CUT_ENABLE:   eta_cut_on       = data[3:0];
      REG_CONST_THRESHOLDS: const_min_packed = data[31:0];
      default: ;
    endcase
  endfunction

  function automatic void report_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random backpressure, result checking, hang detection
  // ---------------------------------------------------------------------------

  // stalls come in random bursts; none once the steady phase starts
  initial begin : drive_out_ready
    int stall;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      stall = (!steady && $urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // every crossing transaction must match the oldest owed crossing
  always @(posedge clk) begin
    logic [CROSSING_W-1:0] owed;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (selected_q.size() == 0) begin
        report_failure($sformatf("unexpected crossing %0d", out_selected_crossing));
      end else begin
        owed = selected_q.pop_front();
        if (out_selected_crossing !== owed)
          report_failure($sformatf("selected_crossing: expected %0d, got %0d",
                                   owed, out_selected_crossing));
      end
    end
  end

  // any transaction on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // one jet transaction, optionally preceded by a short idle burst; valid is held
  // across back-to-back calls so it is never dropped and raised in the same step
  task automatic send_jet(logic [CROSSING_W-1:0] xing, logic [PT_W-1:0] pt,
                          logic signed [ETA_W-1:0] eta, logic [CONST_W-1:0] nc,
                          logic last);
    int gap;
    if (!steady && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_crossing         <= xing;
    in_jet_pt           <= pt;
    in_jet_eta          <= eta;
    in_jet_constituents <= nc;
    in_last_in_crossing <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    count_jet(xing, pt, eta, nc, last);
  endtask

  // stop the jet stream and let every owed crossing come out, then let the
  // pipeline empty of jets that select nothing
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (selected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    store_reg(idx, data);
  endtask

  // fill the bits above a register's width with noise; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] pad_noise(logic [CFG_DATA_W-1:0] value, int width);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    for (int b = width; b < CFG_DATA_W; b++) value[b] = noise[b];
    return value;
  endfunction

  // full register set, written only once the block has gone quiet
  task automatic load_config(logic [COUNT_W-1:0] min_jets, logic [43:0] pt,
                             logic [31:0] eta_lim, logic [3:0] eta_en, logic [31:0] cmin);
    drain_results();
    write_reg(REG_MIN_JET_COUNT,    pad_noise(CFG_DATA_W'(min_jets), COUNT_W));
    write_reg(REG_PT_THRESHOLDS,    pad_noise(pt, 44));
    write_reg(REG_ETA_LIMITS,       pad_noise(CFG_DATA_W'(eta_lim), 32));
    write_reg(REG_ETA_CUT_ENABLE,   pad_noise(CFG_DATA_W'(eta_en), 4));
    write_reg(REG_CONST_THRESHOLDS, pad_noise(CFG_DATA_W'(cmin), 32));
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // pick jet fields around the cuts of the slot the next jet will be tested against,
  // so that both sides of every boundary are hit often
  task automatic aim_jet(output logic [PT_W-1:0] pt, output logic signed [ETA_W-1:0] eta,
                         output logic [CONST_W-1:0] nc);
    int unsigned slot;
    logic [PT_W-1:0] pt_thr;
    logic [7:0]      eta_lim;
    logic [7:0]      c_thr;
    slot    = (jets_taken < NUM_SLOTS) ? jets_taken : $urandom_range(NUM_SLOTS - 1);
    pt_thr  = pt_min_packed[PT_W*slot +: PT_W];
    eta_lim = eta_max_packed[8*slot +: 8];
    c_thr   = const_min_packed[8*slot +: 8];
    case ($urandom_range(3))
      0:       pt = 11'($urandom);
      1:       pt = pt_thr;
      2:       pt = pt_thr - 1'b1;
      default: pt = 11'(pt_thr + $urandom_range(40));
    endcase
    case ($urandom_range(4))
      0:       eta = 8'($urandom);
      1:       eta = 8'(int'(eta_lim) - 1);
      2:       eta = 8'(1 - int'(eta_lim));
      3:       eta = eta_lim;
      default: eta = 8'($urandom_range(30) - 15);
    endcase
    case ($urandom_range(3))
      0:       nc = 8'($urandom);
      1:       nc = c_thr;
      2:       nc = c_thr - 1'b1;
      default: nc = 8'(c_thr + $urandom_range(5));
    endcase
  endtask

  // mostly whole crossings of 1 to 6 jets aimed at the cuts, with stray jets and
  // the odd foreign crossing number mixed in
  task automatic run_phase(int n_items);
    int sent;
    int len;
    logic [CROSSING_W-1:0]   xing;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic [CONST_W-1:0]      nc;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        xing = 12'($urandom);
        pt   = 11'($urandom);
        eta  = 8'($urandom);
        nc   = 8'($urandom);
        send_jet(xing, pt, eta, nc, 1'($urandom));
        sent++;
      end else begin
        len  = $urandom_range(1, 6);
        xing = 12'($urandom);
        for (int k = 0; k < len; k++) begin
          aim_jet(pt, eta, nc);
          send_jet(($urandom_range(15) == 0) ? 12'($urandom) : xing, pt, eta, nc, k == len - 1);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers at reset: requirement zero, so every marked jet yields its crossing
  task automatic test_reset_defaults();
    send_jet(12'd0, 11'd0, 8'sd0, 8'd0, 1'b1);
    send_jet(12'd4095, 11'd2047, -8'sd128, 8'd255, 1'b0);
    send_jet(12'd4095, 11'd2047, 8'sd127, 8'd255, 1'b1);
    // crossing number comes from the marked jet, not the first one
    send_jet(12'd100, 11'd5, -8'sd1, 8'd1, 1'b0);
    send_jet(12'd200, 11'd5, 8'sd1, 8'd1, 1'b1);
  endtask

  // walk all four slots, with cuts failing on their boundaries before slots 0 to 2 pass
  task automatic test_slot_cuts();
    load_config(3'd4, {11'd20, 11'd10, 11'd2047, 11'd0}, {8'd255, 8'd5, 8'd0, 8'd128},
                4'b1101, {8'd0, 8'd3, 8'd255, 8'd0});
    send_jet(12'd7, 11'd0, -8'sd128, 8'd0, 1'b0);    // slot 0: |eta| 128 not below 128
    send_jet(12'd7, 11'd0, 8'sd127, 8'd0, 1'b0);     // slot 0 passes
    send_jet(12'd7, 11'd2046, -8'sd128, 8'd255, 1'b0); // slot 1: pt one short
    send_jet(12'd7, 11'd2047, -8'sd128, 8'd255, 1'b0); // slot 1 passes, eta cut off
    send_jet(12'd7, 11'd10, -8'sd5, 8'd3, 1'b0);     // slot 2: |eta| equals limit
    send_jet(12'd7, 11'd10, -8'sd4, 8'd2, 1'b0);     // slot 2: too few constituents
    send_jet(12'd7, 11'd9, 8'sd4, 8'd3, 1'b0);       // slot 2: pt one short
    send_jet(12'd7, 11'd10, 8'sd4, 8'd3, 1'b0);      // slot 2 passes
    send_jet(12'd7, 11'd2047, -8'sd128, 8'd0, 1'b1); // slot 3 passes, crossing selected
  endtask

  // requirement met early, a crossing that falls short, and a requirement past the slots
  task automatic test_met_and_unreachable();
    load_config(3'd1, '0, '0, 4'h0, '0);
    send_jet(12'd55, 11'd3, 8'sd0, 8'd0, 1'b0);
    send_jet(12'd55, 11'd0, -8'sd128, 8'd0, 1'b0);   // ignored, count already met
    send_jet(12'd56, 11'd1, 8'sd2, 8'd9, 1'b1);
    load_config(3'd2, '1, '0, 4'h0, '0);
    send_jet(12'd60, 11'd2046, 8'sd0, 8'd0, 1'b0);
    send_jet(12'd60, 11'd100, 8'sd0, 8'd0, 1'b1);    // nothing passes, nothing selected
    load_config(3'd7, '0, '0, 4'h0, '0);
    for (int k = 0; k < 5; k++) send_jet(12'd70, 11'd0, 8'sd0, 8'd0, k == 4);
    // writes to unused indexes must not disturb the unreachable requirement
    drain_results();
    for (int i = NUM_CFG_REGS; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'({$urandom, $urandom}));
    @(negedge clk) cfg_valid <= 1'b0;
    for (int k = 0; k < 5; k++) send_jet(12'd71, 11'd0, 8'sd0, 8'd0, k == 4);
  endtask

  task automatic random_config(logic [COUNT_W-1:0] min_jets);
    logic [43:0] pt;
    logic [31:0] eta_lim;
    logic [31:0] cmin;
    for (int s = 0; s < PACKED_SLOTS; s++) begin
      pt[PT_W*s +: PT_W] = ($urandom_range(2) == 0) ? 11'($urandom) : 11'($urandom_range(200));
      eta_lim[8*s +: 8]  = 8'($urandom);
      cmin[8*s +: 8]     = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(20));
    end
    load_config(min_jets, pt, eta_lim, 4'($urandom), cmin);
  endtask

  // random crossings under extreme and random settings; the last phase runs without idling
  task automatic test_random_crossings();
    // loosest cuts: |eta| 128 still below 255
    idle_pct = 20;
    load_config(3'd4, '0, '1, 4'hF, '0);
    run_phase(ITEMS_PER_PHASE);
    // tightest pt and constituent cuts with eta cuts off
    idle_pct = 30;
    load_config(3'd4, '1, '0, 4'h0, '1);
    run_phase(ITEMS_PER_PHASE);
    for (int p = 0; p < 4; p++) begin
      idle_pct = $urandom_range(30);
      random_config(3'($urandom_range(4)));
      run_phase(ITEMS_PER_PHASE);
    end
    idle_pct = 0;
    random_config(3'd0);
    run_phase(ITEMS_PER_PHASE / 2);
    steady = 1'b1;
    random_config(3'd2);
    run_phase(ITEMS_PER_PHASE);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_n               = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_crossing         = '0;
    in_jet_pt           = '0;
    in_jet_eta          = '0;
    in_jet_constituents = '0;
    in_last_in_crossing = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_defaults();
    test_slot_cuts();
    test_met_and_unreachable();
    test_random_crossings();
    drain_results();

    if (failures == 0 && selected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[jet_multiplicity_bx_selector_core.f]
design/jmbs_pkg.sv
design/jmbs_front.sv
design/jmbs_fifo.sv
design/jmbs_back.sv
design/jet_multiplicity_bx_selector_core.sv
test/tb_jet_multiplicity_bx_selector_core.sv
